// ===== rtl/prrb_pkg.sv =====
// shared types, register map and reset values of the poll request scheduler
package prrb_pkg;

    // time base width, default for the top level parameter
    localparam int TIME_WIDTH_DEF = 32;

    // configuration port geometry
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 3;

    // register indexes (paddr[4:2])
    localparam logic [INDEX_W-1:0] REG_BASE_PERIOD    = 3'd0;
    localparam logic [INDEX_W-1:0] REG_BACKOFF_PERIOD = 3'd1;
    localparam logic [INDEX_W-1:0] REG_MIN_TX_GAP     = 3'd2;
    localparam logic [INDEX_W-1:0] REG_REPLY_TIMEOUT  = 3'd3;
    localparam logic [INDEX_W-1:0] REG_RETRY_LIMIT    = 3'd4;
    localparam logic [INDEX_W-1:0] REG_BACKOFF_AFTER  = 3'd5;

    // reset values of the registers
    localparam logic [15:0] BASE_PERIOD_RST    = 16'd250;
    localparam logic [15:0] BACKOFF_PERIOD_RST = 16'd1000;
    localparam logic [15:0] MIN_TX_GAP_RST     = 16'd20;
    localparam logic [15:0] REPLY_TIMEOUT_RST  = 16'd80;
    localparam logic [3:0]  RETRY_LIMIT_RST    = 4'd2;
    localparam logic [7:0]  BACKOFF_AFTER_RST  = 8'd3;

    // streak saturation value
    localparam logic [7:0] STREAK_MAX = 8'hFF;

    // input item action codes
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_REPLY = 1'b1;

    typedef struct packed {
        logic [15:0] base_period_ms;
        logic [15:0] backoff_period_ms;
        logic [15:0] min_tx_gap_ms;
        logic [15:0] reply_timeout_ms;
        logic [3:0]  retry_limit;
        logic [7:0]  backoff_after;
    } cfg_t;

    typedef struct packed {
        logic        action;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic        send_request;
        logic [3:0]  attempt_index;
        logic        gave_up;
        logic        backed_off;
        logic        awaiting_reply;
        logic [7:0]  timeout_streak;
        logic [31:0] last_ok_ms;
    } out_item_t;

endpackage

// ===== rtl/prrb_regs.sv =====
// configuration register file with apb-style access
module prrb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prrb_pkg::ADDR_W-1:0]   paddr,
    input  logic [prrb_pkg::DATA_W-1:0]   pwdata,
    output logic [prrb_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output prrb_pkg::cfg_t                cfg
);

    prrb_pkg::cfg_t                  cfg_reg;
    logic [prrb_pkg::INDEX_W-1:0]    index;
    logic                            wr_en;

    assign index  = paddr[prrb_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_period_ms    <= prrb_pkg::BASE_PERIOD_RST;
            cfg_reg.backoff_period_ms <= prrb_pkg::BACKOFF_PERIOD_RST;
            cfg_reg.min_tx_gap_ms     <= prrb_pkg::MIN_TX_GAP_RST;
            cfg_reg.reply_timeout_ms  <= prrb_pkg::REPLY_TIMEOUT_RST;
            cfg_reg.retry_limit       <= prrb_pkg::RETRY_LIMIT_RST;
            cfg_reg.backoff_after     <= prrb_pkg::BACKOFF_AFTER_RST;
        end
        else if (wr_en)
        begin
            unique case (index)
                prrb_pkg::REG_BASE_PERIOD:    cfg_reg.base_period_ms    <= pwdata[15:0];
                prrb_pkg::REG_BACKOFF_PERIOD: cfg_reg.backoff_period_ms <= pwdata[15:0];
                prrb_pkg::REG_MIN_TX_GAP:     cfg_reg.min_tx_gap_ms     <= pwdata[15:0];
                prrb_pkg::REG_REPLY_TIMEOUT:  cfg_reg.reply_timeout_ms  <= pwdata[15:0];
                prrb_pkg::REG_RETRY_LIMIT:    cfg_reg.retry_limit       <= pwdata[3:0];
                prrb_pkg::REG_BACKOFF_AFTER:  cfg_reg.backoff_after     <= pwdata[7:0];
                default:                      ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (index)
            prrb_pkg::REG_BASE_PERIOD:    prdata = {16'd0, cfg_reg.base_period_ms};
            prrb_pkg::REG_BACKOFF_PERIOD: prdata = {16'd0, cfg_reg.backoff_period_ms};
            prrb_pkg::REG_MIN_TX_GAP:     prdata = {16'd0, cfg_reg.min_tx_gap_ms};
            prrb_pkg::REG_REPLY_TIMEOUT:  prdata = {16'd0, cfg_reg.reply_timeout_ms};
            prrb_pkg::REG_RETRY_LIMIT:    prdata = {28'd0, cfg_reg.retry_limit};
            prrb_pkg::REG_BACKOFF_AFTER:  prdata = {24'd0, cfg_reg.backoff_after};
            default:                      prdata = '0;
        endcase
    end

endmodule

// ===== rtl/prrb_core.sv =====
// scheduler state and single-pass next-state logic for one item
module prrb_core #(
    parameter int TIME_WIDTH = prrb_pkg::TIME_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  prrb_pkg::in_item_t   item,
    input  prrb_pkg::cfg_t       cfg,
    output prrb_pkg::out_item_t  result
);

    logic                  pending_reg,     pending_next;
    logic [3:0]            retries_reg,     retries_next;
    logic [7:0]            failed_reg,      failed_next;
    logic [TIME_WIDTH-1:0] cycle_start_reg, cycle_start_next;
    logic [TIME_WIDTH-1:0] last_tx_reg,     last_tx_next;
    logic [TIME_WIDTH-1:0] attempt_reg,     attempt_next;
    logic                  backoff_reg,     backoff_next;
    logic [TIME_WIDTH-1:0] reply_reg,       reply_next;

    logic [TIME_WIDTH-1:0] now_t;
    logic                  timed_out;
    logic                  gap_ok;
    logic                  can_retry;
    logic                  give;
    logic                  resend;
    logic                  start;
    logic                  pending_mid;
    logic                  backoff_mid;
    logic [7:0]            failed_mid;
    logic [15:0]           period;
    logic [3:0]            retry_inc;

    // wrapping signed difference, elapsed when non-negative and at least thr
    function automatic logic elapsed(input logic [TIME_WIDTH-1:0] now_v,
                                     input logic [TIME_WIDTH-1:0] then_v,
                                     input logic [15:0]           thr);
        logic [TIME_WIDTH-1:0] d;
        begin
            d = now_v - then_v;
            return !d[TIME_WIDTH-1] && (d >= TIME_WIDTH'(thr));
        end
    endfunction

    assign now_t       = TIME_WIDTH'(item.now_ms);
    assign timed_out   = pending_reg && elapsed(now_t, attempt_reg, cfg.reply_timeout_ms);
    assign gap_ok      = elapsed(now_t, last_tx_reg, cfg.min_tx_gap_ms);
    assign can_retry   = retries_reg < cfg.retry_limit;
    assign give        = timed_out && !can_retry;
    assign resend      = timed_out && can_retry && gap_ok;
    assign retry_inc   = 4'(retries_reg + 4'd1);
    assign failed_mid  = give ? ((failed_reg == prrb_pkg::STREAK_MAX) ? failed_reg
                                                                       : 8'(failed_reg + 8'd1))
                              : failed_reg;
    assign backoff_mid = give ? (failed_mid >= cfg.backoff_after) : backoff_reg;
    assign pending_mid = pending_reg && !give;
    assign period      = backoff_mid ? cfg.backoff_period_ms : cfg.base_period_ms;
    // a resend keeps the request pending, so it never meets a new cycle start
    assign start       = !pending_mid && gap_ok && elapsed(now_t, cycle_start_reg, period);

    always_comb
    begin
        pending_next     = pending_reg;
        retries_next     = retries_reg;
        failed_next      = failed_reg;
        cycle_start_next = cycle_start_reg;
        last_tx_next     = last_tx_reg;
        attempt_next     = attempt_reg;
        backoff_next     = backoff_reg;
        reply_next       = reply_reg;
        result           = '0;

        if (item.action == prrb_pkg::ACT_REPLY)
        begin
            reply_next   = now_t;
            pending_next = 1'b0;
            retries_next = 4'd0;
            failed_next  = 8'd0;
            backoff_next = 1'b0;
        end
        else
        begin
            failed_next  = failed_mid;
            backoff_next = backoff_mid;
            pending_next = pending_mid || start;
            if (start)
            begin
                retries_next     = 4'd0;
                cycle_start_next = now_t;
            end
            else if (resend)
            begin
                retries_next = retry_inc;
            end
            if (start || resend)
            begin
                last_tx_next = now_t;
                attempt_next = now_t;
            end
            result.send_request  = start || resend;
            result.attempt_index = start ? 4'd0 : (resend ? retry_inc : 4'd0);
            result.gave_up       = give;
        end

        result.backed_off     = backoff_next;
        result.awaiting_reply = pending_next;
        result.timeout_streak = failed_next;
        result.last_ok_ms     = 32'(reply_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg     <= 1'b0;
            retries_reg     <= 4'd0;
            failed_reg      <= 8'd0;
            cycle_start_reg <= '0;
            last_tx_reg     <= '0;
            attempt_reg     <= '0;
            backoff_reg     <= 1'b0;
            reply_reg       <= '0;
        end
        else if (advance)
        begin
            pending_reg     <= pending_next;
            retries_reg     <= retries_next;
            failed_reg      <= failed_next;
            cycle_start_reg <= cycle_start_next;
            last_tx_reg     <= last_tx_next;
            attempt_reg     <= attempt_next;
            backoff_reg     <= backoff_next;
            reply_reg       <= reply_next;
        end
    end

endmodule

// ===== rtl/poll_request_retry_backoff_unit.sv =====
// top level of the periodic poll scheduler with reply timeout, retry and back-off
//
// usage
//   item channel: item_valid / item_ready / item carry a tick (action 0) or a
//   valid reply (action 1) with the current millisecond time in now_ms
//   result channel: result_valid / result_ready / result give exactly one
//   result item per input item, in order: send_request tells the bus side to
//   transmit a query frame, plus retry index, give-up, back-off and status
//   config: apb-style port, registers at byte address 4*index, pready always
//   high, written at the access cycle; change them only while the block is idle
// timing
//   an item goes into an input register, is evaluated in one pass against the
//   scheduler state and lands in the result register: result_valid rises one
//   cycle after the accepting edge, throughput one item per cycle, set by the
//   single-pass compare logic between the two registers
// reset
//   rst_n low clears both pipeline stages, the scheduler state (nothing
//   pending, base period, zero streak, all times zero) and loads the register
//   defaults
// stall
//   while result_ready is low the result holds; one more item can wait in the
//   input register, after that item_ready drops until the result is taken
module poll_request_retry_backoff_unit #(
    parameter int TIME_WIDTH = prrb_pkg::TIME_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // item channel
    input  logic                         item_valid,
    output logic                         item_ready,
    input  prrb_pkg::in_item_t           item,
    // result channel
    output logic                         result_valid,
    input  logic                         result_ready,
    output prrb_pkg::out_item_t          result,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [prrb_pkg::ADDR_W-1:0]  paddr,
    input  logic [prrb_pkg::DATA_W-1:0]  pwdata,
    output logic [prrb_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    prrb_pkg::cfg_t       cfg;
    prrb_pkg::in_item_t   item_reg;
    logic                 item_valid_reg;
    prrb_pkg::out_item_t  result_reg;
    prrb_pkg::out_item_t  result_next;
    logic                 result_valid_reg;
    logic                 out_free;
    logic                 advance;

    // result slot is free when empty or being emptied this cycle
    assign out_free     = !result_valid_reg || result_ready;
    // the held item is evaluated and retired into the result register
    assign advance      = item_valid_reg && out_free;
    assign item_ready   = !item_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    prrb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    prrb_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result_next)
    );

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (out_free)
            begin
                result_valid_reg <= advance;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    // a transmission always leaves a request outstanding
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.send_request |-> result.awaiting_reply)
        else $error("send without outstanding request");

    // retry index only carries meaning with a transmission
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.send_request |-> result.attempt_index == 4'd0)
        else $error("attempt index without send");

    // abandoning a cycle always counts a failure
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.gave_up |-> result.timeout_streak != 8'd0)
        else $error("give-up with empty streak");

    // back-off is only entered after at least one failed cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.backed_off |-> result.timeout_streak != 8'd0)
        else $error("back-off with empty streak");
`endif

endmodule
